[hw/rtl/hcbd_pkg.sv]
package hcbd_pkg;

  // body_mode register values (three is handled like until-close)
  localparam logic [1:0] MODE_CLOSE   = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;
  localparam logic [1:0] MODE_CHUNKED = 2'd2;

  // configuration register indexes
  localparam logic CFG_BODY_MODE      = 1'b0;
  localparam logic CFG_CONTENT_LENGTH = 1'b1;

  // result status codes
  localparam logic [2:0] ST_PAYLOAD = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_BAD_FT  = 3'd3;
  localparam logic [2:0] ST_BAD_TR  = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UPR_A = 8'h41;
  localparam logic [7:0] CH_UPR_F = 8'h46;
  localparam logic [7:0] CH_LWR_A = 8'h61;
  localparam logic [7:0] CH_LWR_F = 8'h66;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       body_last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    logic [7:0] t;
    h = '0;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      h.valid = 1'b1;
    end else if (c >= CH_UPR_A && c <= CH_UPR_F) begin
      t = c - CH_UPR_A + 8'd10;
      h.valid = 1'b1;
    end else if (c >= CH_LWR_A && c <= CH_LWR_F) begin
      t = c - CH_LWR_A + 8'd10;
      h.valid = 1'b1;
    end
    h.value = t[3:0];
    return h;
  endfunction

endpackage

[hw/rtl/hcbd_core.sv]
module hcbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 restart,
  input  logic [1:0]           body_mode,
  input  logic [31:0]          content_length,
  input  logic                 byte_fire,
  input  logic [7:0]           stream_byte,
  output hcbd_pkg::result_t    res
);

  // counter also holds the fixed content length, so never narrower than 32
  localparam int CNT_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_EXT       = 4'd1,
    PH_HDR_LF    = 4'd2,
    PH_DATA      = 4'd3,
    PH_FOOT_CR   = 4'd4,
    PH_FOOT_LF   = 4'd5,
    PH_TR_START  = 4'd6,
    PH_TR_LINE   = 4'd7,
    PH_TR_LF     = 4'd8,
    PH_TR_END_LF = 4'd9,
    PH_DONE      = 4'd10,
    PH_ERR_HDR   = 4'd11,
    PH_ERR_FOOT  = 4'd12,
    PH_ERR_TR    = 4'd13,
    PH_FIXED     = 4'd14
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  hcbd_pkg::hex_t   hex;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] fix_src;
  logic [CNT_W-1:0] fix_dec;
  logic             is_cr;
  logic             is_lf;

  assign hex     = hcbd_pkg::hex_digit(stream_byte);
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign fix_src = (phase_r == PH_FIXED) ? cnt_r : CNT_W'(content_length);
  assign fix_dec = fix_src - CNT_W'(1);
  assign is_cr   = (stream_byte == hcbd_pkg::CH_CR);
  assign is_lf   = (stream_byte == hcbd_pkg::CH_LF);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    res       = '0;
    if (body_mode == hcbd_pkg::MODE_FIXED) begin
      if (phase_r != PH_DONE) begin
        if (phase_r != PH_FIXED && content_length == 32'd0) begin
          phase_nxt     = PH_DONE;
          cnt_nxt       = '0;
          res.valid     = 1'b1;
          res.status    = hcbd_pkg::ST_END;
          res.body_last = 1'b1;
        end else begin
          cnt_nxt          = fix_dec;
          phase_nxt        = (fix_dec == '0) ? PH_DONE : PH_FIXED;
          res.valid        = 1'b1;
          res.payload_byte = stream_byte;
          res.status       = hcbd_pkg::ST_PAYLOAD;
          res.body_last    = (fix_dec == '0);
        end
      end
    end else if (body_mode == hcbd_pkg::MODE_CHUNKED) begin
      unique case (phase_r)
        PH_START: begin
          if (hex.valid) begin
            if (cnt_r[SIZE_BITS-1:SIZE_BITS-4] != 4'd0) ovf_nxt = 1'b1;
            cnt_nxt = CNT_W'({cnt_r[SIZE_BITS-5:0], hex.value});
          end else begin
            phase_nxt = is_cr ? PH_HDR_LF : PH_EXT;
          end
        end
        PH_EXT: begin
          if (is_cr) phase_nxt = PH_HDR_LF;
        end
        PH_HDR_LF: begin
          if (!is_lf || ovf_r) begin
            phase_nxt     = PH_ERR_HDR;
            res.valid     = 1'b1;
            res.status    = hcbd_pkg::ST_BAD_HDR;
            res.body_last = 1'b1;
          end else begin
            phase_nxt = (cnt_r == '0) ? PH_TR_START : PH_DATA;
          end
        end
        PH_DATA: begin
          cnt_nxt          = cnt_dec;
          if (cnt_dec == '0) phase_nxt = PH_FOOT_CR;
          res.valid        = 1'b1;
          res.payload_byte = stream_byte;
          res.status       = hcbd_pkg::ST_PAYLOAD;
        end
        PH_FOOT_CR: begin
          if (!is_cr) begin
            phase_nxt     = PH_ERR_FOOT;
            res.valid     = 1'b1;
            res.status    = hcbd_pkg::ST_BAD_FT;
            res.body_last = 1'b1;
          end else begin
            phase_nxt = PH_FOOT_LF;
          end
        end
        PH_FOOT_LF: begin
          if (!is_lf) begin
            phase_nxt     = PH_ERR_FOOT;
            res.valid     = 1'b1;
            res.status    = hcbd_pkg::ST_BAD_FT;
            res.body_last = 1'b1;
          end else begin
            phase_nxt = PH_START;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        PH_TR_START: phase_nxt = is_cr ? PH_TR_END_LF : PH_TR_LINE;
        PH_TR_LINE: begin
          if (is_cr) phase_nxt = PH_TR_LF;
        end
        PH_TR_LF: begin
          if (!is_lf) begin
            phase_nxt     = PH_ERR_TR;
            res.valid     = 1'b1;
            res.status    = hcbd_pkg::ST_BAD_TR;
            res.body_last = 1'b1;
          end else begin
            phase_nxt = PH_TR_START;
          end
        end
        PH_TR_END_LF: begin
          res.valid     = 1'b1;
          res.body_last = 1'b1;
          if (!is_lf) begin
            phase_nxt  = PH_ERR_TR;
            res.status = hcbd_pkg::ST_BAD_TR;
          end else begin
            phase_nxt  = PH_DONE;
            res.status = hcbd_pkg::ST_END;
          end
        end
        // sticky errors repeat their code without body_last
        PH_ERR_HDR: begin
          res.valid  = 1'b1;
          res.status = hcbd_pkg::ST_BAD_HDR;
        end
        PH_ERR_FOOT: begin
          res.valid  = 1'b1;
          res.status = hcbd_pkg::ST_BAD_FT;
        end
        PH_ERR_TR: begin
          res.valid  = 1'b1;
          res.status = hcbd_pkg::ST_BAD_TR;
        end
        default: begin
        end
      endcase
    end else begin
      res.valid        = 1'b1;
      res.payload_byte = stream_byte;
      res.status       = hcbd_pkg::ST_PAYLOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r <= PH_START;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (byte_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

[hw/rtl/http_chunked_body_decoder_top.sv]
// HTTP/1.1 reply body decoder: takes one body byte per request and returns at most one
// result per byte (payload byte, body end or a sticky framing error). The parse state
// and chunk counter register on each accepted byte, and results land in one output register,
// so a byte is accepted every cycle while out_ready is high or the output register is
// empty; in_ready follows out_ready combinationally. A write to either configuration
// register restarts the body and is meant to be issued only while the block is idle.
// SIZE_BITS sets how many bits of chunk size are kept before a size overflow is flagged.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_status,
  output logic        out_body_last
);

  logic [1:0]  body_mode_r;
  logic [31:0] content_length_r;

  logic        out_valid_r;
  logic [7:0]  out_payload_byte_r;
  logic [2:0]  out_status_r;
  logic        out_body_last_r;

  logic              byte_fire;
  hcbd_pkg::result_t res;

  assign in_ready  = !out_valid_r || out_ready;
  assign byte_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r      <= hcbd_pkg::MODE_CLOSE;
      content_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcbd_pkg::CFG_BODY_MODE:      body_mode_r      <= cfg_data[1:0];
        hcbd_pkg::CFG_CONTENT_LENGTH: content_length_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hcbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (cfg_we),
    .body_mode      (body_mode_r),
    .content_length (content_length_r),
    .byte_fire      (byte_fire),
    .stream_byte    (in_stream_byte),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (byte_fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire && res.valid) begin
      out_payload_byte_r <= res.payload_byte;
      out_status_r       <= res.status;
      out_body_last_r    <= res.body_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_byte_r;
  assign out_status       = out_status_r;
  assign out_body_last    = out_body_last_r;

endmodule
